### rtl/hcbp_pkg.sv
// Shared types, request codes and widths of the Huffman code bit packer.
package hcbp_pkg;

    localparam int REQ_W       = 2;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 6;
    localparam int CODE_BITS_W = 32;
    localparam int BYTE_W      = 8;
    localparam int ACC_W       = 7;
    localparam int CNT_W       = 3;
    localparam int TOT_W       = 6;
    localparam int RES_MAX     = 4;
    localparam int RES_CNT_W   = 3;
    localparam int IDX_W       = 2;
    localparam int VAL_W       = ACC_W + CODE_BITS_W;
    localparam int LINE_W      = BYTE_W * (RES_MAX + 1);

    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int DEF_SYMBOLS      = 256;

    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

    typedef struct packed {
        logic [RES_MAX-1:0][BYTE_W-1:0] bytes;
        logic [RES_CNT_W-1:0]           n;
        logic                           flush;
        logic                           bvalid;
        logic [CNT_W-1:0]               tail;
    } result_t;

endpackage

### rtl/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer: table, packing stage and result buffer.
//
// The input channel (in_valid/in_ready) takes one request word per handshake:
// a load word writes the length and code of one symbol into the code table, an
// encode word appends the code of its symbol to the bit stream, and a flush word
// returns the partial byte left over together with its count of valid bits.
// The output channel (out_valid/out_ready) returns one result word per byte;
// the word "last" marks the final result of the request that caused it.
// The table read register and the packing stage register both load at the
// accepting edge, and the results of the request are then registered in the
// result buffer before the first result word is offered. Loads produce no result.
// An encode produces zero to four result words and a flush exactly one, and the
// single byte-wide output port limits throughput: a request waits in the packing
// stage until the result buffer has handed out the last word of the one before.
// Requests without results pass at one per cycle while the stage is not held.
// Reset clears the bit accumulator, the pending count and all handshake state;
// the code table is not cleared, so a symbol must be loaded before it is
// encoded. When the receiver stalls, the result buffer holds its word, the
// packing stage waits behind it, and in_ready drops once that stage is full.
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOLS      = hcbp_pkg::DEF_SYMBOLS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [hcbp_pkg::REQ_W-1:0]         req_type,
    input  logic [hcbp_pkg::SYM_W-1:0]         symbol,
    input  logic [hcbp_pkg::LEN_W-1:0]         code_len,
    input  logic [hcbp_pkg::CODE_BITS_W-1:0]   code_bits,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]        data_byte,
    output logic                               byte_valid,
    output logic [hcbp_pkg::CNT_W-1:0]         tail_bits,
    output logic                               flush_done,
    output logic                               last
);

    // Stored code width; longer codes are saturated to this length at load.
    localparam int CODE_W = (MAX_CODE_LEN < hcbp_pkg::CODE_BITS_W)
                          ? MAX_CODE_LEN : hcbp_pkg::CODE_BITS_W;
    localparam int AW     = $clog2(SYMBOLS);

    logic                        accept;
    logic                        sym_ok;
    logic [hcbp_pkg::LEN_W-1:0]  sat_len;
    logic                        tbl_wr;
    logic                        tbl_rd;
    logic [hcbp_pkg::LEN_W-1:0]  entry_len;
    logic [CODE_W-1:0]           entry_code;
    logic                        buf_free;
    logic                        push;
    hcbp_pkg::result_t           res;

    assign accept  = in_valid && in_ready;
    // Symbols past the end of the table are dropped on load and add no bits.
    assign sym_ok  = ({1'b0, symbol} < (hcbp_pkg::SYM_W+1)'(SYMBOLS));
    assign sat_len = (code_len > hcbp_pkg::LEN_W'(CODE_W))
                   ? hcbp_pkg::LEN_W'(CODE_W) : code_len;
    assign tbl_wr  = accept && (req_type == hcbp_pkg::REQ_LOAD) && sym_ok;
    assign tbl_rd  = accept && (req_type == hcbp_pkg::REQ_ENCODE);

    hcbp_code_table #(
        .SYMBOLS (SYMBOLS),
        .CODE_W  (CODE_W),
        .AW      (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr),
        .wr_addr (symbol[AW-1:0]),
        .wr_len  (sat_len),
        .wr_code (code_bits[CODE_W-1:0]),
        .rd_en   (tbl_rd),
        .rd_addr (symbol[AW-1:0]),
        .rd_len  (entry_len),
        .rd_code (entry_code)
    );

    hcbp_packer #(
        .CODE_W (CODE_W)
    ) u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (accept),
        .req_type   (req_type),
        .sym_ok     (sym_ok),
        .entry_len  (entry_len),
        .entry_code (entry_code),
        .buf_free   (buf_free),
        .ready      (in_ready),
        .push       (push),
        .res        (res)
    );

    hcbp_out_buffer u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .res        (res),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .free       (buf_free),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .tail_bits  (tail_bits),
        .flush_done (flush_done),
        .last       (last)
    );

endmodule

### rtl/hcbp_code_table.sv
// Code table memory: one length and code per symbol, registered read.
module hcbp_code_table #(
    parameter int SYMBOLS = hcbp_pkg::DEF_SYMBOLS,
    parameter int CODE_W  = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int AW      = $clog2(SYMBOLS)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [hcbp_pkg::LEN_W-1:0]   wr_len,
    input  logic [CODE_W-1:0]            wr_code,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [hcbp_pkg::LEN_W-1:0]   rd_len,
    output logic [CODE_W-1:0]            rd_code
);

    localparam int ENTRY_W = hcbp_pkg::LEN_W + CODE_W;

    logic [ENTRY_W-1:0] mem [SYMBOLS];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_len, wr_code};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_len  = rd_data_reg[ENTRY_W-1:CODE_W];
    assign rd_code = rd_data_reg[CODE_W-1:0];

endmodule

### rtl/hcbp_packer.sv
// Packing stage: merges a looked-up code into the bit accumulator and cuts bytes.
module hcbp_packer #(
    parameter int CODE_W = hcbp_pkg::DEF_MAX_CODE_LEN
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [hcbp_pkg::REQ_W-1:0]    req_type,
    input  logic                          sym_ok,
    input  logic [hcbp_pkg::LEN_W-1:0]    entry_len,
    input  logic [CODE_W-1:0]             entry_code,
    input  logic                          buf_free,
    output logic                          ready,
    output logic                          push,
    output hcbp_pkg::result_t             res
);

    logic                        s1_valid_reg;
    logic [hcbp_pkg::REQ_W-1:0]  s1_req_reg;
    logic                        s1_ok_reg;
    logic [hcbp_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [hcbp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    logic [hcbp_pkg::LEN_W-1:0]  eff_len;
    logic [CODE_W-1:0]           code_mask;
    logic [CODE_W-1:0]           code_masked;
    logic [hcbp_pkg::VAL_W-1:0]  merged;
    logic [hcbp_pkg::TOT_W-1:0]  total;
    logic [hcbp_pkg::TOT_W-1:0]  shift_amt;
    logic [hcbp_pkg::LINE_W-1:0] line;
    logic [hcbp_pkg::CNT_W-1:0]  rem;
    logic                        fire;

    assign eff_len     = s1_ok_reg ? entry_len : '0;
    assign code_mask   = CODE_W'((CODE_W+1)'(1) << eff_len) - CODE_W'(1);
    assign code_masked = entry_code & code_mask;
    assign merged      = (hcbp_pkg::VAL_W'(acc_reg) << eff_len)
                       | hcbp_pkg::VAL_W'(code_masked);
    assign total       = hcbp_pkg::TOT_W'(cnt_reg) + eff_len;
    assign shift_amt   = hcbp_pkg::TOT_W'(hcbp_pkg::LINE_W) - total;
    // Left-align the pending bits so the full bytes sit at the top of the line.
    assign line        = hcbp_pkg::LINE_W'(merged) << shift_amt;
    assign rem         = total[hcbp_pkg::CNT_W-1:0];

    always_comb
    begin
        res      = '0;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        unique case (s1_req_reg)
            hcbp_pkg::REQ_ENCODE:
            begin
                for (int k = 0; k < hcbp_pkg::RES_MAX; k++)
                begin
                    res.bytes[k] = line[hcbp_pkg::LINE_W-1-hcbp_pkg::BYTE_W*k -:
                                        hcbp_pkg::BYTE_W];
                end
                res.n    = total[hcbp_pkg::TOT_W-1:hcbp_pkg::CNT_W];
                res.flush  = 1'b0;
                res.bvalid = 1'b1;
                acc_next = hcbp_pkg::ACC_W'(merged)
                         & hcbp_pkg::ACC_W'((8'(1) << rem) - 8'(1));
                cnt_next = rem;
            end
            hcbp_pkg::REQ_FLUSH:
            begin
                res.bytes[0] = hcbp_pkg::BYTE_W'(acc_reg);
                res.n        = hcbp_pkg::RES_CNT_W'(1);
                res.flush    = 1'b1;
                res.bvalid   = (cnt_reg != '0);
                res.tail     = cnt_reg;
                acc_next     = '0;
                cnt_next     = '0;
            end
            default:
            begin
                res.n = '0;
            end
        endcase
    end

    assign fire  = s1_valid_reg && ((res.n == '0) || buf_free);
    assign push  = fire && (res.n != '0);
    assign ready = !s1_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_req_reg   <= hcbp_pkg::REQ_LOAD;
            s1_ok_reg    <= 1'b0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (fire)
            begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_next;
            end
            if (take)
            begin
                s1_valid_reg <= 1'b1;
                s1_req_reg   <= req_type;
                s1_ok_reg    <= sym_ok;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/hcbp_out_buffer.sv
// Result buffer: holds one item's results and hands them out one word at a time.
module hcbp_out_buffer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  hcbp_pkg::result_t             res,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          free,
    output logic [hcbp_pkg::BYTE_W-1:0]   data_byte,
    output logic                          byte_valid,
    output logic [hcbp_pkg::CNT_W-1:0]    tail_bits,
    output logic                          flush_done,
    output logic                          last
);

    logic                        valid_reg;
    logic [hcbp_pkg::IDX_W-1:0]  idx_reg;
    hcbp_pkg::result_t           res_reg;
    logic                        is_last;

    assign is_last    = (hcbp_pkg::RES_CNT_W'(idx_reg) == (res_reg.n - 1'b1));
    assign out_valid  = valid_reg;
    assign free       = !valid_reg || (out_ready && is_last);
    assign data_byte  = res_reg.bytes[idx_reg];
    assign byte_valid = res_reg.bvalid;
    assign tail_bits  = res_reg.tail;
    assign flush_done = res_reg.flush;
    assign last       = is_last;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && out_ready)
        begin
            if (is_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

endmodule

### test/tb.sv
// Self-checking testbench of the Huffman code bit packer, with its scoreboard class.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hcbp_pkg::*;

    // Request code 3 has no meaning; the block must drop the word without a result.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Longest code the table keeps; longer lengths are saturated on load.
    localparam int LEN_CAP = (DEF_MAX_CODE_LEN < 32) ? DEF_MAX_CODE_LEN : 32;

    localparam int RANDOM_ITEMS = 470;
    localparam int HOLD_CYCLES  = 120;
    localparam int TAIL_CYCLES  = 20;
    localparam int TIMEOUT_NS   = 2_000_000;

    // The scoreboard keeps its own copy of the code table and of the bit
    // accumulator, and turns every accepted request word into the result
    // words the block has to return, oldest first.
    class packer_scoreboard;
        typedef struct packed {
            logic [BYTE_W-1:0] data;
            logic              bvalid;
            logic [CNT_W-1:0]  tail;
            logic              flush;
            logic              lst;
        } out_word_t;

        logic [LEN_W-1:0]       entry_len [DEF_SYMBOLS];
        logic [CODE_BITS_W-1:0] entry_code[DEF_SYMBOLS];
        logic [BYTE_W-1:0]      acc;
        int                     nbits;
        out_word_t              words_due[$];
        int                     errors;

        function new();
            acc    = '0;
            nbits  = 0;
            errors = 0;
        endfunction

        function void note_input(input logic [REQ_W-1:0] req, input logic [SYM_W-1:0] sym,
                                 input logic [LEN_W-1:0] len,
                                 input logic [CODE_BITS_W-1:0] bits);
            out_word_t w;
            int        first;
            first = words_due.size();
            case (req)
                REQ_LOAD:
                begin
                    if (int'(sym) < DEF_SYMBOLS)
                    begin
                        if (int'(len) > LEN_CAP)
                            entry_len[sym] = LEN_W'(LEN_CAP);
                        else
                            entry_len[sym] = len;
                        entry_code[sym] = bits;
                    end
                end
                REQ_ENCODE:
                begin
                    if (int'(sym) < DEF_SYMBOLS)
                    begin
                        for (int i = int'(entry_len[sym]) - 1; i >= 0; i--)
                        begin
                            acc = {acc[BYTE_W-2:0], entry_code[sym][i]};
                            nbits++;
                            if (nbits == BYTE_W)
                            begin
                                w = '{data: acc, bvalid: 1'b1, tail: '0, flush: 1'b0,
                                      lst: 1'b0};
                                words_due = {words_due, w};
                                acc   = '0;
                                nbits = 0;
                            end
                        end
                    end
                    if (words_due.size() > first)
                    begin
                        w     = words_due.pop_back();
                        w.lst = 1'b1;
                        words_due = {words_due, w};
                    end
                end
                REQ_FLUSH:
                begin
                    // The partial byte leaves unshifted, its valid bits at the bottom.
                    if (nbits != 0)
                        w = '{data: acc, bvalid: 1'b1, tail: CNT_W'(nbits), flush: 1'b1,
                              lst: 1'b1};
                    else
                        w = '{data: '0, bvalid: 1'b0, tail: '0, flush: 1'b1, lst: 1'b1};
                    words_due = {words_due, w};
                    acc   = '0;
                    nbits = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(input logic [BYTE_W-1:0] data, input logic bvalid,
                                   input logic [CNT_W-1:0] tail, input logic flush,
                                   input logic lst);
            out_word_t got;
            out_word_t want;
            got = '{data: data, bvalid: bvalid, tail: tail, flush: flush, lst: lst};
            if (words_due.size() == 0)
            begin
                errors++;
                $display("%0t: result word with none expected: data=%h valid=%b tail=%0d flush=%b last=%b",
                         $time, data, bvalid, tail, flush, lst);
                return;
            end
            want = words_due.pop_front();
            if (got.data !== want.data || got.bvalid !== want.bvalid || got.tail !== want.tail
                || got.flush !== want.flush || got.lst !== want.lst)
            begin
                errors++;
                $display("%0t: mismatch expected data=%h valid=%b tail=%0d flush=%b last=%b, actual data=%h valid=%b tail=%0d flush=%b last=%b",
                         $time, want.data, want.bvalid, want.tail, want.flush, want.lst,
                         got.data, got.bvalid, got.tail, got.flush, got.lst);
            end
        endfunction
    endclass

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic [REQ_W-1:0]       req_type   = REQ_LOAD;
    logic [SYM_W-1:0]       symbol     = '0;
    logic [LEN_W-1:0]       code_len   = '0;
    logic [CODE_BITS_W-1:0] code_bits  = '0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [BYTE_W-1:0]      data_byte;
    logic                   byte_valid;
    logic [CNT_W-1:0]       tail_bits;
    logic                   flush_done;
    logic                   last;

    // Phase controls. The sender reads sender_steady itself; the other two
    // steer the receiver process and are therefore updated at clock edges.
    bit sender_steady = 1'b0;
    bit rx_steady     = 1'b0;
    bit hold_go       = 1'b0;

    // Symbols whose table entry holds a written value; only these are encoded.
    logic [SYM_W-1:0] loaded_syms[$];
    bit               is_loaded[DEF_SYMBOLS];

    packer_scoreboard sb;

    huffman_code_bit_packer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .symbol     (symbol),
        .code_len   (code_len),
        .code_bits  (code_bits),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .tail_bits  (tail_bits),
        .flush_done (flush_done),
        .last       (last)
    );

    always #2 clk = ~clk;

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one request word and returns at the edge where it was taken.
    // The caller is then still inside that edge's time step, so the next call
    // either keeps in_valid high with a new payload or drops it for a gap.
    task automatic send_word(input logic [REQ_W-1:0] req, input logic [SYM_W-1:0] sym,
                             input logic [LEN_W-1:0] len,
                             input logic [CODE_BITS_W-1:0] bits);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        symbol    <= sym;
        code_len  <= len;
        code_bits <= bits;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(req, sym, len, bits);
    endtask

    task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                              input logic [CODE_BITS_W-1:0] bits);
        send_word(REQ_LOAD, sym, len, bits);
        if (!is_loaded[sym])
        begin
            is_loaded[sym] = 1'b1;
            loaded_syms = {loaded_syms, sym};
        end
    endtask

    // Stops offering words until every expected result word has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.words_due.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: checks each accepted result word and stalls at random. Once
    // the stimulus raises hold_go it holds out_ready low for a long count of
    // cycles, so the packing stage backs up and in_ready has to fall.
    initial
    begin
        int stall_left;
        bit hold_seen;
        stall_left = 0;
        hold_seen  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(data_byte, byte_valid, tail_bits, flush_done, last);
            if (hold_go && !hold_seen)
            begin
                hold_seen  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !rx_steady && $urandom_range(0, 99) < 30)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Stimulus: a directed opening, then random traffic in phases.
    initial
    begin
        int               n_sent;
        int               r;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
        sb     = new();
        n_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // A flush with no bits pending returns an empty, flagged word.
        send_word(REQ_FLUSH, 8'd0, 6'd0, 32'd0);
        // The unused request code must vanish without a trace.
        send_word(REQ_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
        // A zero-length code adds no bits at all.
        load_entry(8'd0, 6'd0, 32'hFFFF_FFFF);
        send_word(REQ_ENCODE, 8'd0, 6'd0, 32'd0);
        // A full 32-bit code from an empty accumulator gives four bytes.
        load_entry(8'd255, 6'd32, 32'hA5C3_0FF1);
        send_word(REQ_ENCODE, 8'd255, 6'd0, 32'd0);
        // An oversized length is cut back to the largest code length.
        load_entry(8'd1, 6'd63, 32'hFFFF_FFFF);
        send_word(REQ_ENCODE, 8'd1, 6'd0, 32'd0);
        // Seven bits pending plus 32 more: four bytes, seven bits left over.
        load_entry(8'd2, 6'd7, 32'h0000_0055);
        send_word(REQ_ENCODE, 8'd2, 6'd0, 32'd0);
        send_word(REQ_ENCODE, 8'd255, 6'd0, 32'd0);
        send_word(REQ_FLUSH, 8'd0, 6'd0, 32'd0);
        // A single pending bit is flushed as the low bit with a count of one.
        load_entry(8'd3, 6'd1, 32'h0000_0001);
        send_word(REQ_ENCODE, 8'd3, 6'd0, 32'd0);
        send_word(REQ_FLUSH, 8'd0, 6'd0, 32'd0);
        // An exactly aligned byte leaves nothing for the flush.
        load_entry(8'd4, 6'd8, 32'h0000_0000);
        send_word(REQ_ENCODE, 8'd4, 6'd0, 32'd0);
        send_word(REQ_FLUSH, 8'd0, 6'd0, 32'd0);
        load_entry(8'd5, 6'd33, 32'h1234_5678);
        send_word(REQ_ENCODE, 8'd2, 6'd0, 32'd0);
        send_word(REQ_ENCODE, 8'd5, 6'd0, 32'd0);
        send_word(REQ_ENCODE, 8'd1, 6'd0, 32'd0);
        send_word(REQ_ENCODE, 8'd3, 6'd0, 32'd0);
        send_word(REQ_FLUSH, 8'd0, 6'd0, 32'd0);
        // Reloading an entry must replace both its length and its code.
        load_entry(8'd255, 6'd5, 32'h0000_0013);
        send_word(REQ_ENCODE, 8'd255, 6'd0, 32'd0);
        send_word(REQ_ENCODE, 8'd255, 6'd0, 32'd0);

        while (n_sent < RANDOM_ITEMS)
        begin
            // Full-rate burst into a long receiver hold-off, so the block fills up.
            if (n_sent == 150)
            begin
                sender_steady = 1'b1;
                hold_go      <= 1'b1;
            end
            if (n_sent == 190)
                sender_steady = 1'b0;
            // Let the block run completely dry in the middle of the run.
            if (n_sent == 300)
                wait_drained();
            // A stretch with no idling on either side.
            if (n_sent == 350)
            begin
                sender_steady = 1'b1;
                rx_steady    <= 1'b1;
            end
            if (n_sent == 400)
            begin
                sender_steady = 1'b0;
                rx_steady    <= 1'b0;
            end

            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                sym = SYM_W'($urandom_range(0, DEF_SYMBOLS - 1));
                r   = $urandom_range(0, 99);
                if (r < 8)
                    len = 6'd0;
                else if (r < 60)
                    len = LEN_W'($urandom_range(1, 8));
                else if (r < 85)
                    len = LEN_W'($urandom_range(9, 20));
                else if (r < 95)
                    len = LEN_W'($urandom_range(21, 32));
                else
                    len = LEN_W'($urandom_range(33, 63));
                load_entry(sym, len, $urandom);
                n_sent++;
            end
            else if (r < 22)
            begin
                send_word(REQ_FLUSH, SYM_W'($urandom), LEN_W'($urandom), $urandom);
                n_sent++;
            end
            else if (r < 25)
                send_word(REQ_UNUSED, SYM_W'($urandom), LEN_W'($urandom), $urandom);
            else
            begin
                sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
                send_word(REQ_ENCODE, sym, LEN_W'($urandom), $urandom);
                n_sent++;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.words_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Guard against a block that stops answering.
    initial
    begin
        #TIMEOUT_NS;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
